>>> rtl/core/tsr_pkg.sv
// Shared types and constants for the touch swipe recogniser.
package tsr_pkg;

    // Event kinds
    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    // Swipe directions
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Reported controller states
    localparam logic [1:0] GST_NONE       = 2'd0;
    localparam logic [1:0] GST_COLLECTING = 2'd1;
    localparam logic [1:0] GST_RECOGNISED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW    = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_FACTOR    = 2'd2;
    localparam logic [1:0] CFG_ALLOWED   = 2'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // Configuration reset values
    localparam logic [9:0]  RST_WINDOW    = 10'd100;
    localparam logic [11:0] RST_THRESHOLD = 12'd80;
    localparam logic [3:0]  RST_FACTOR    = 4'd4;
    localparam logic [3:0]  RST_ALLOWED   = 4'd0;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        contact_id;
        logic               has_coords;
        logic signed [15:0] touch_x;
        logic signed [15:0] touch_y;
        logic [31:0]        time_ms;
    } t_in_beat;

    typedef struct packed {
        logic       handled;
        logic       began;
        logic       swipe_done;
        logic [1:0] swipe_direction;
        logic       gesture_ended;
        logic [1:0] controller_state;
    } t_out_beat;

    typedef struct packed {
        logic [9:0]  window_ms;
        logic [11:0] distance_threshold;
        logic [3:0]  proportion_factor;
        logic [3:0]  allowed_directions;
    } t_cfg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PRUNE_RD,
        S_PRUNE_CHK,
        S_STORE,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MAG,
        S_DECIDE,
        S_CLOSE,
        S_FINISH
    } t_fsm;

    // Commands from sequencer to datapath
    typedef struct packed {
        logic load_in;
        logic reject;
        logic clear_pts;
        logic clr_touch;
        logic set_touch;
        logic rd_oldest;
        logic pop;
        logic store;
        logic scan_init;
        logic rd_scan;
        logic scan_dec;
        logic take_diff;
        logic take_mag;
        logic decide;
        logic close;
        logic load_out;
    } t_cmd;

    // Status from datapath to sequencer
    typedef struct packed {
        logic [1:0] kind;
        logic       has;
        logic       foreign;
        logic       swiping;
        logic       count_zero;
        logic       prune_hit;
        logic       scan_stop;
        logic       out_free;
    } t_status;

endpackage

>>> rtl/core/tsr_ctrl.sv
// Sequencer for the swipe recogniser: steps one event through prune, store, scan and decide.
module tsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tsr_pkg::t_status  i_status,
    output tsr_pkg::t_cmd     o_cmd
);
    import tsr_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_status.kind == KIND_CANCEL) begin
                    o_cmd.clear_pts = 1'b1;
                    o_cmd.clr_touch = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_status.foreign) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_FINISH;
                end else if (i_status.kind == KIND_BEGIN) begin
                    o_cmd.clear_pts = 1'b1;
                    o_cmd.set_touch = 1'b1;
                    n_state         = i_status.has ? S_STORE : S_FINISH;
                end else if (i_status.has) begin
                    n_state = S_PRUNE_RD;
                end else if (i_status.kind == KIND_UPDATE || i_status.swiping) begin
                    n_state = S_SCAN_INIT;
                end else begin
                    n_state = S_CLOSE;
                end
            end
            S_PRUNE_RD: begin
                if (i_status.count_zero) begin
                    n_state = S_STORE;
                end else begin
                    o_cmd.rd_oldest = 1'b1;
                    n_state         = S_PRUNE_CHK;
                end
            end
            S_PRUNE_CHK: begin
                if (i_status.prune_hit) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_PRUNE_RD;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                priority if (i_status.kind == KIND_BEGIN) begin
                    n_state = S_FINISH;
                end else if (i_status.kind == KIND_UPDATE || i_status.swiping) begin
                    n_state = S_SCAN_INIT;
                end else begin
                    n_state = S_CLOSE;
                end
            end
            S_SCAN_INIT: begin
                if (i_status.count_zero) begin
                    n_state = (i_status.kind == KIND_UPDATE) ? S_FINISH : S_CLOSE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_status.scan_stop) begin
                    o_cmd.take_diff = 1'b1;
                    n_state         = S_MAG;
                end else begin
                    o_cmd.scan_dec = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_MAG: begin
                o_cmd.take_mag = 1'b1;
                n_state        = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = (i_status.kind == KIND_UPDATE) ? S_FINISH : S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/tsr_dp.sv
// Datapath for the swipe recogniser: point ring, touch state, direction arithmetic, result beat.
module tsr_dp #(
    parameter int unsigned WINDOW_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsr_pkg::t_in_beat  i_in_data,
    input  tsr_pkg::t_cfg      i_cfg,
    input  tsr_pkg::t_cmd      i_cmd,
    output tsr_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tsr_pkg::t_out_beat o_out_data
);
    import tsr_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        t;
    } t_point;

    // Ring position of the entry ofs places after base
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
        logic [AW:0] s;
        s = (AW+1)'(base) + (AW+1)'(ofs);
        if (s >= (AW+1)'(WINDOW_DEPTH)) begin
            s = s - (AW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Point ring
    t_point r_mem [WINDOW_DEPTH];
    t_point r_rd;

    // Event being worked on
    logic [1:0]         r_kind;
    logic [15:0]        r_contact;
    logic               r_has;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [31:0]        r_t;

    // Touch state
    logic [AW-1:0] r_oldest;
    logic [CW-1:0] r_count;
    logic          r_active;
    logic [15:0]   r_owner;
    logic          r_swiping;

    // Newest stored point, scan index, displacement
    logic signed [15:0] r_new_x;
    logic signed [15:0] r_new_y;
    logic [31:0]        r_new_t;
    logic [AW-1:0]      r_k;
    logic [16:0]        r_dx;
    logic [16:0]        r_dy;
    logic [15:0]        r_ax;
    logic [15:0]        r_ay;
    logic               r_neg_x;
    logic               r_neg_y;

    // Result flags
    logic       r_handled;
    logic       r_began;
    logic       r_sw_end;
    logic [1:0] r_dir;
    logic       r_g_end;
    t_out_beat  r_out;
    logic       r_out_valid;

    logic          full;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] oldest_inc;
    logic [32:0]   rd_limit;
    logic [16:0]   neg_dx;
    logic [16:0]   neg_dy;
    logic [19:0]   prod_x;
    logic [19:0]   prod_y;
    logic          hor;
    logic          ver;
    logic [1:0]    cand_dir;
    logic          found;
    logic [1:0]    cur_state;

    assign full       = (r_count == CW'(WINDOW_DEPTH));
    assign wr_addr    = f_slot(r_oldest, r_count);
    assign rd_addr    = i_cmd.rd_scan ? f_slot(r_oldest, CW'(r_k)) : r_oldest;
    assign oldest_inc = f_slot(r_oldest, CW'(1));
    assign rd_limit   = {1'b0, r_rd.t} + 33'(i_cfg.window_ms);

    // Magnitudes and direction test
    assign neg_dx   = 17'd0 - r_dx;
    assign neg_dy   = 17'd0 - r_dy;
    assign prod_y   = {4'b0, r_ay} * {16'b0, i_cfg.proportion_factor};
    assign prod_x   = {4'b0, r_ax} * {16'b0, i_cfg.proportion_factor};
    assign hor      = (r_ax > {4'b0, i_cfg.distance_threshold}) && ({4'b0, r_ax} > prod_y);
    assign ver      = (r_ay > {4'b0, i_cfg.distance_threshold}) && ({4'b0, r_ay} > prod_x);
    assign cand_dir = hor ? (r_neg_x ? DIR_LEFT : DIR_RIGHT)
                          : (r_neg_y ? DIR_UP : DIR_DOWN);
    assign found    = (hor || ver) && i_cfg.allowed_directions[cand_dir];

    assign cur_state = !r_active     ? GST_NONE :
                       r_swiping     ? GST_RECOGNISED :
                       (r_count != '0) ? GST_COLLECTING : GST_NONE;

    // Status back to the sequencer
    assign o_status.kind       = r_kind;
    assign o_status.has        = r_has;
    assign o_status.foreign    = r_active && (r_contact != r_owner);
    assign o_status.swiping    = r_swiping;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.prune_hit  = (rd_limit <= {1'b0, r_t});
    assign o_status.scan_stop  = (rd_limit < {1'b0, r_new_t}) || (r_k == '0);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // Write and read the ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[wr_addr] <= '{x: r_x, y: r_y, t: r_t};
        end
        if (i_cmd.rd_oldest || i_cmd.rd_scan) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Touch control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_count   <= '0;
            r_active  <= 1'b0;
            r_owner   <= '0;
            r_swiping <= 1'b0;
        end else begin
            if (i_cmd.clear_pts || i_cmd.close) begin
                r_oldest  <= '0;
                r_count   <= '0;
                r_swiping <= 1'b0;
            end else if (i_cmd.pop) begin
                r_oldest <= oldest_inc;
                r_count  <= r_count - CW'(1);
            end else if (i_cmd.store) begin
                if (full) begin
                    r_oldest <= oldest_inc;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end else if (i_cmd.decide && r_kind == KIND_UPDATE && found) begin
                r_swiping <= 1'b1;
            end
            if (i_cmd.clr_touch || i_cmd.close) begin
                r_active <= 1'b0;
            end else if (i_cmd.set_touch) begin
                r_active <= 1'b1;
                r_owner  <= r_contact;
            end
        end
    end

    // Event capture, newest point, scan and arithmetic registers, result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind    <= i_in_data.kind;
            r_contact <= i_in_data.contact_id;
            r_has     <= i_in_data.has_coords;
            r_x       <= i_in_data.touch_x;
            r_y       <= i_in_data.touch_y;
            r_t       <= i_in_data.time_ms;
            r_handled <= 1'b1;
            r_began   <= 1'b0;
            r_sw_end  <= 1'b0;
            r_dir     <= DIR_LEFT;
            r_g_end   <= 1'b0;
        end
        if (i_cmd.reject) begin
            r_handled <= 1'b0;
        end
        if (i_cmd.store) begin
            r_new_x <= r_x;
            r_new_y <= r_y;
            r_new_t <= r_t;
        end
        if (i_cmd.scan_init) begin
            r_k <= AW'(r_count - CW'(1));
        end else if (i_cmd.scan_dec) begin
            r_k <= r_k - AW'(1);
        end
        if (i_cmd.take_diff) begin
            r_dx <= {r_new_x[15], r_new_x} - {r_rd.x[15], r_rd.x};
            r_dy <= {r_new_y[15], r_new_y} - {r_rd.y[15], r_rd.y};
        end
        if (i_cmd.take_mag) begin
            r_neg_x <= r_dx[16];
            r_neg_y <= r_dy[16];
            r_ax    <= r_dx[16] ? neg_dx[15:0] : r_dx[15:0];
            r_ay    <= r_dy[16] ? neg_dy[15:0] : r_dy[15:0];
        end
        if (i_cmd.decide) begin
            if (r_kind == KIND_UPDATE) begin
                r_began <= found;
            end else begin
                r_sw_end <= found;
                r_dir    <= found ? cand_dir : DIR_LEFT;
            end
        end
        if (i_cmd.close) begin
            r_g_end <= r_swiping;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.handled          <= r_handled;
            r_out.began            <= r_began;
            r_out.swipe_done       <= r_sw_end;
            r_out.swipe_direction  <= r_dir;
            r_out.gesture_ended    <= r_g_end;
            r_out.controller_state <= cur_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/touch_swipe_recognizer_core.sv
// Steps: cancel, a rejected event or a bare begin go from dispatch straight to the result;
// a begin with coordinates is stored first; other events prune and store when they carry
// coordinates, then scan the point ring through its registered read port and decide as needed.
// Throughput: one event at a time; the next is accepted the cycle after the result is
// registered, and a result still stalled at the output holds the next one back.
// Reset (synchronous, active low): touch state, handshakes and configuration to defaults.
module touch_swipe_recognizer_core #(
    parameter int unsigned WINDOW_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tsr_pkg::t_in_beat                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tsr_pkg::t_out_beat                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tsr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tsr_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms          <= RST_WINDOW;
            r_cfg.distance_threshold <= RST_THRESHOLD;
            r_cfg.proportion_factor  <= RST_FACTOR;
            r_cfg.allowed_directions <= RST_ALLOWED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW:    r_cfg.window_ms          <= i_cfg_data[9:0];
                CFG_THRESHOLD: r_cfg.distance_threshold <= i_cfg_data[11:0];
                CFG_FACTOR:    r_cfg.proportion_factor  <= i_cfg_data[3:0];
                CFG_ALLOWED:   r_cfg.allowed_directions <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    tsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tsr_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
